/* rtl/pdf_pkg.sv */
`default_nettype none
package pdf_pkg;

    localparam int VEL_W     = 32;
    localparam int TAG_W     = 16;
    localparam int COEF_W    = 24;
    localparam int CFG_IDX_W = 8;
    localparam int SPEED_W   = 32;
    localparam int SUM_W     = 64;
    localparam int REM_W     = SPEED_W + 2;
    localparam int KPROD_W   = COEF_W + SPEED_W;
    localparam int FACTOR_W  = KPROD_W - 16 + 1;
    localparam int FH_W      = FACTOR_W - 32;
    localparam int PH_W      = VEL_W + FH_W;
    localparam int PL_W      = 2 * VEL_W;
    localparam int Q_W       = PH_W + 17;

    localparam logic [COEF_W-1:0] DRAG_COEF_RESET     = 24'd58982;
    localparam logic [COEF_W-1:0] DRAG_COEF_SQR_RESET = 24'd52429;

    localparam logic [CFG_IDX_W-1:0] CFG_DRAG_COEF     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAG_COEF_SQR = 8'd1;

    localparam logic [VEL_W-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [VEL_W-1:0] NEG_MAX = 32'h8000_0000;

    typedef struct packed {
        logic                        vld;
        logic                        applied;
        logic [TAG_W-1:0]            tag;
        logic [2:0]                  neg;
        logic [2:0][VEL_W-1:0]       mag;
    } t_side;

endpackage
`default_nettype wire

/* rtl/pdf_vel_if.sv */
`default_nettype none
interface pdf_vel_if;
    import pdf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] vel_z;
    logic [TAG_W-1:0]        particle_tag;

    modport source (output valid, vel_x, vel_y, vel_z, particle_tag, input ready);
    modport sink   (input valid, vel_x, vel_y, vel_z, particle_tag, output ready);
endinterface
`default_nettype wire

/* rtl/pdf_force_if.sv */
`default_nettype none
interface pdf_force_if;
    import pdf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VEL_W-1:0] force_x;
    logic signed [VEL_W-1:0] force_y;
    logic signed [VEL_W-1:0] force_z;
    logic                    applied;
    logic [TAG_W-1:0]        result_tag;

    modport source (output valid, force_x, force_y, force_z, applied, result_tag,
                    input ready);
    modport sink   (input valid, force_x, force_y, force_z, applied, result_tag,
                    output ready);
endinterface
`default_nettype wire

/* rtl/pdf_isqrt.sv */
`default_nettype none
module pdf_isqrt (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_en,
    input  wire pdf_pkg::t_side           i_side,
    input  wire [pdf_pkg::SUM_W-1:0]      i_rad,
    output pdf_pkg::t_side                o_side,
    output logic [pdf_pkg::SPEED_W-1:0]   o_root
);
    import pdf_pkg::*;

    t_side              s_side [0:SPEED_W];
    logic [SUM_W-1:0]   s_rad  [0:SPEED_W];
    logic [REM_W-1:0]   s_rem  [0:SPEED_W];
    logic [SPEED_W-1:0] s_root [0:SPEED_W];

    assign s_side[0] = i_side;
    assign s_rad[0]  = i_rad;
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;

    genvar j;
    generate
        for (j = 0; j < SPEED_W; j++) begin : g_stage
            logic [REM_W+1:0]   n_pre;
            logic [REM_W+1:0]   n_trial;
            logic               n_ge;
            logic [REM_W+1:0]   n_diff;
            t_side              r_side;
            logic [SUM_W-1:0]   r_rad;
            logic [REM_W-1:0]   r_rem;
            logic [SPEED_W-1:0] r_root;

            always_comb begin
                n_pre   = {s_rem[j], s_rad[j][SUM_W-1 -: 2]};
                n_trial = {2'b00, s_root[j], 2'b01};
                n_ge    = (n_pre >= n_trial);
                n_diff  = n_pre - n_trial;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_side.vld <= 1'b0;
                end else if (i_en) begin
                    r_side.vld <= s_side[j].vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_side.applied <= s_side[j].applied;
                    r_side.tag     <= s_side[j].tag;
                    r_side.neg     <= s_side[j].neg;
                    r_side.mag     <= s_side[j].mag;
                    r_rad          <= {s_rad[j][SUM_W-3:0], 2'b00};
                    r_rem          <= n_ge ? n_diff[REM_W-1:0] : n_pre[REM_W-1:0];
                    r_root         <= {s_root[j][SPEED_W-2:0], n_ge};
                end
            end

            assign s_side[j+1] = r_side;
            assign s_rad[j+1]  = r_rad;
            assign s_rem[j+1]  = r_rem;
            assign s_root[j+1] = r_root;
        end
    endgenerate

    assign o_side = s_side[SPEED_W];
    assign o_root = s_root[SPEED_W];

    logic unused_tail;
    assign unused_tail = ^{s_rad[SPEED_W], s_rem[SPEED_W]};
endmodule
`default_nettype wire

/* rtl/particle_drag_force.sv */
// Drag force generator, one particle per beat.
// Input beats on i_vel carry a signed Q16.16 velocity and a tag; output beats
// on o_force carry force = -v * (k1 + k2 * |v|), each component saturated to
// signed 32 bits, with applied low for a zero velocity and the tag copied.
// k1 and k2 (unsigned Q8.16) are written through i_cfg_we / i_cfg_idx /
// i_cfg_data: index 0 is k1, index 1 is k2, other indexes are dropped.
// Write them only while no beat is in flight.
// The pipeline has three stages for magnitude, squares and sum, 32 for
// the square root (one result bit per stage), and four for the coefficient
// product, factor, component products and saturation.
// Throughput is one beat per cycle while the receiver does not stall.
// When the receiver stalls, the whole pipeline holds and i_vel.ready drops;
// nothing is lost or repeated.
// Synchronous reset empties the pipeline and loads k1 = 0.9, k2 = 0.8.
`default_nettype none
module particle_drag_force (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    pdf_vel_if.sink                           i_vel,
    pdf_force_if.source                       o_force,
    input  wire                               i_cfg_we,
    input  wire [pdf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [pdf_pkg::COEF_W-1:0]         i_cfg_data
);
    import pdf_pkg::*;

    logic [COEF_W-1:0] r_k1;
    logic [COEF_W-1:0] r_k2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k1 <= DRAG_COEF_RESET;
            r_k2 <= DRAG_COEF_SQR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DRAG_COEF:     r_k1 <= i_cfg_data;
                CFG_DRAG_COEF_SQR: r_k2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic  r_en;
    t_side r_s0, r_s1, r_s2, r_s3, r_s4, r_s5;
    t_side n_s0;
    t_side w_sq_side;
    logic [SPEED_W-1:0]          w_speed;
    logic [2:0][SUM_W-1:0]       r_sq;
    logic [SUM_W-1:0]            r_sum;
    logic [KPROD_W-1:0]          r_kprod;
    logic [FACTOR_W-1:0]         r_factor;
    logic [2:0][PL_W-1:0]        r_pl;
    logic [2:0][PH_W-1:0]        r_ph;
    logic                        r_out_vld;
    logic [2:0][VEL_W-1:0]       r_force;
    logic                        r_applied;
    logic [TAG_W-1:0]            r_tag;
    logic [2:0][VEL_W-1:0]       w_vel;
    logic [2:0][Q_W-1:0]         n_q;
    logic [2:0][VEL_W-1:0]       n_force;

    assign r_en        = !r_out_vld || o_force.ready;
    assign i_vel.ready = r_en;

    assign w_vel[0] = i_vel.vel_x;
    assign w_vel[1] = i_vel.vel_y;
    assign w_vel[2] = i_vel.vel_z;

    always_comb begin
        n_s0.vld     = i_vel.valid;
        n_s0.tag     = i_vel.particle_tag;
        n_s0.applied = |{i_vel.vel_x, i_vel.vel_y, i_vel.vel_z};
        for (int c = 0; c < 3; c++) begin
            n_s0.neg[c] = w_vel[c][VEL_W-1];
            n_s0.mag[c] = w_vel[c][VEL_W-1] ? (~w_vel[c] + 1'b1) : w_vel[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.vld  <= 1'b0;
            r_s1.vld  <= 1'b0;
            r_s2.vld  <= 1'b0;
            r_s3.vld  <= 1'b0;
            r_s4.vld  <= 1'b0;
            r_s5.vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (r_en) begin
            r_s0.vld  <= n_s0.vld;
            r_s1.vld  <= r_s0.vld;
            r_s2.vld  <= r_s1.vld;
            r_s3.vld  <= w_sq_side.vld;
            r_s4.vld  <= r_s3.vld;
            r_s5.vld  <= r_s4.vld;
            r_out_vld <= r_s5.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_en) begin
            {r_s0.applied, r_s0.tag, r_s0.neg, r_s0.mag} <=
                {n_s0.applied, n_s0.tag, n_s0.neg, n_s0.mag};
            {r_s1.applied, r_s1.tag, r_s1.neg, r_s1.mag} <=
                {r_s0.applied, r_s0.tag, r_s0.neg, r_s0.mag};
            {r_s2.applied, r_s2.tag, r_s2.neg, r_s2.mag} <=
                {r_s1.applied, r_s1.tag, r_s1.neg, r_s1.mag};
            {r_s3.applied, r_s3.tag, r_s3.neg, r_s3.mag} <=
                {w_sq_side.applied, w_sq_side.tag, w_sq_side.neg, w_sq_side.mag};
            {r_s4.applied, r_s4.tag, r_s4.neg, r_s4.mag} <=
                {r_s3.applied, r_s3.tag, r_s3.neg, r_s3.mag};
            {r_s5.applied, r_s5.tag, r_s5.neg, r_s5.mag} <=
                {r_s4.applied, r_s4.tag, r_s4.neg, r_s4.mag};

            for (int c = 0; c < 3; c++) begin
                r_sq[c] <= SUM_W'(r_s0.mag[c]) * SUM_W'(r_s0.mag[c]);
            end
            r_sum    <= r_sq[0] + r_sq[1] + r_sq[2];
            r_kprod  <= KPROD_W'(r_k2) * KPROD_W'(w_speed);
            r_factor <= FACTOR_W'(r_k1) + FACTOR_W'(r_kprod[KPROD_W-1:16]);
            for (int c = 0; c < 3; c++) begin
                r_pl[c] <= PL_W'(r_s4.mag[c]) * PL_W'(r_factor[31:0]);
                r_ph[c] <= PH_W'(r_s4.mag[c]) * PH_W'(r_factor[FACTOR_W-1:32]);
            end
            r_force   <= n_force;
            r_applied <= r_s5.applied;
            r_tag     <= r_s5.tag;
        end
    end

    pdf_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_en),
        .i_side  (r_s2),
        .i_rad   (r_sum),
        .o_side  (w_sq_side),
        .o_root  (w_speed)
    );

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_q[c] = {1'b0, r_ph[c], 16'b0} + Q_W'(r_pl[c][PL_W-1:16]);
            if (r_s5.neg[c]) begin
                n_force[c] = (n_q[c] > Q_W'(POS_MAX)) ? POS_MAX : n_q[c][VEL_W-1:0];
            end else begin
                n_force[c] = (n_q[c] > Q_W'(NEG_MAX)) ? NEG_MAX
                                                     : (VEL_W'(0) - n_q[c][VEL_W-1:0]);
            end
        end
    end

    assign o_force.valid      = r_out_vld;
    assign o_force.force_x    = r_force[0];
    assign o_force.force_y    = r_force[1];
    assign o_force.force_z    = r_force[2];
    assign o_force.applied    = r_applied;
    assign o_force.result_tag = r_tag;

    a_zero_force: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_force.valid && !o_force.applied |->
            o_force.force_x == '0 && o_force.force_y == '0 && o_force.force_z == '0)
        else $error("zero velocity gave nonzero force");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_en |=> $stable(r_sum) && $stable(r_factor) && $stable(r_s2.vld))
        else $error("pipeline moved during stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_force.valid && !r_s0.vld)
        else $error("pipeline not empty after reset");
endmodule
`default_nettype wire
